### rtl/assert_macros.svh
// Assertion helpers for the assertion checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ESP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ESP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/esp_pkg.sv
`default_nettype none

package esp_pkg;

    localparam int ADDR_W   = 5;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int STEP_W   = 4;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 50;
    localparam int DUTY_Q_W = ACC_W - 10;

    typedef enum logic [1:0] {
        FUNC_EDGE   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_TARGET = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_PROP   = 3'd0,
        REG_INTEG  = 3'd1,
        REG_DERIV  = 3'd2,
        REG_BIAS   = 3'd3,
        REG_WINDOW = 3'd4,
        REG_SCALE  = 3'd5
    } reg_idx_t;

    localparam logic [15:0] PROP_RST   = 16'd1792;
    localparam logic [15:0] INTEG_RST  = 16'd0;
    localparam logic [15:0] DERIV_RST  = 16'd102;
    localparam logic [11:0] BIAS_RST   = 12'd4000;
    localparam logic [15:0] WINDOW_RST = 16'd100;
    localparam logic [15:0] SCALE_RST  = 16'd11648;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_COUNT  = 3'd1,
        OP_TARGET = 3'd2,
        OP_TICK   = 3'd3,
        OP_SPEED  = 3'd4,
        OP_ERR    = 3'd5,
        OP_LAST   = 3'd6,
        OP_DUTY   = 3'd7
    } dp_op_t;

    typedef enum logic [2:0] {
        MUL_NONE       = 3'd0,
        MUL_MAG_SCALE  = 3'd1,
        MUL_ERR_PROP   = 3'd2,
        MUL_SUM_INTEG  = 3'd3,
        MUL_DERR_DERIV = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_BIAS = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic {
        JMP_NEVER = 1'b0,
        JMP_SHORT = 1'b1
    } jump_t;

    localparam logic [STEP_W-1:0] STEP_EDGE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TARGET = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TICK   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MAG    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SPEED  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ERR    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PROP   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_INTEG  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DERIV  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SUM    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DUTY   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_NOP    = 4'd11;

    typedef struct packed {
        dp_op_t            op;
        mul_sel_t          mul;
        acc_op_t           acc;
        jump_t             jump;
        logic [STEP_W-1:0] jump_addr;
        logic              emit;
        logic              done;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{op: OP_NONE, mul: MUL_NONE, acc: ACC_HOLD, jump: JMP_NEVER,
               jump_addr: STEP_NOP, emit: 1'b0, done: 1'b0};
        case (step)
            STEP_EDGE: begin
                cw.op   = OP_COUNT;
                cw.done = 1'b1;
            end
            STEP_TARGET: begin
                cw.op   = OP_TARGET;
                cw.emit = 1'b1;
                cw.done = 1'b1;
            end
            STEP_TICK: begin
                cw.op        = OP_TICK;
                cw.jump      = JMP_SHORT;
                cw.jump_addr = STEP_NOP;
            end
            STEP_MAG: begin
                cw.mul = MUL_MAG_SCALE;
            end
            STEP_SPEED: begin
                cw.op = OP_SPEED;
            end
            STEP_ERR: begin
                cw.op  = OP_ERR;
                cw.acc = ACC_BIAS;
            end
            STEP_PROP: begin
                cw.mul = MUL_ERR_PROP;
            end
            STEP_INTEG: begin
                cw.mul = MUL_SUM_INTEG;
                cw.acc = ACC_ADD;
            end
            STEP_DERIV: begin
                cw.mul = MUL_DERR_DERIV;
                cw.acc = ACC_ADD;
            end
            STEP_SUM: begin
                cw.op  = OP_LAST;
                cw.acc = ACC_ADD;
            end
            STEP_DUTY: begin
                cw.op   = OP_DUTY;
                cw.emit = 1'b1;
                cw.done = 1'b1;
            end
            STEP_NOP: begin
                cw.done = 1'b1;
            end
            default: begin
                cw.done = 1'b1;
            end
        endcase
        return cw;
    endfunction

    function automatic logic [STEP_W-1:0] entry_step(input func_t f);
        logic [STEP_W-1:0] s;
        case (f)
            FUNC_EDGE:   s = STEP_EDGE;
            FUNC_TICK:   s = STEP_TICK;
            FUNC_TARGET: s = STEP_TARGET;
            default:     s = STEP_NOP;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/encoder_speed_pid_pwm.sv
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       tuser: func; tdata: enc_b, target, dir
// m_        out        m_tvalid / m_tready       tdata: pwm_duty, bridge_top, speed
// APB       in         psel / penable / pready   six 32-bit registers at 4*i
//
// Each item runs a step program and the input is not ready until it ends. An encoder
// edge or a new target runs only its own step, a tick that does not close a window runs
// the tick and no-op steps, and a tick that closes one runs on to the duty step, passing
// the four products of the speed and PID update through one shared 33x17 multiplier in turn.
// Reset is synchronous and active low; it restores the register defaults.
// A result step waits while the output register still holds an untaken item.
`default_nettype none

module encoder_speed_pid_pwm #(
    parameter int PWM_BITS    = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: enc_b [0], target_speed [12:1], direction [13], zero [15:14]
    input  logic [esp_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: func [1:0]
    input  logic [esp_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: pwm_duty [11:0], bridge_top [12], measured_speed [28:13], zero [31:29]
    output logic [esp_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import esp_pkg::*;

    localparam logic [DUTY_Q_W-1:0] PWM_MAX = DUTY_Q_W'((64'd1 << PWM_BITS) - 64'd1);
    localparam logic [11:0] TGT_MASK = PWM_MAX[11:0];

    logic [15:0] prop_reg, integ_reg, deriv_reg, window_reg, scale_reg;
    logic [11:0] bias_reg;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    logic        in_b_reg, in_dir_reg;
    logic [11:0] in_target_reg;

    logic [COUNT_WIDTH-1:0] pulse_reg;
    logic [15:0]            tick_reg;
    logic signed [31:0]     esum_reg;
    logic signed [17:0]     last_err_reg;
    logic [11:0]            target_reg;
    logic                   dir_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [15:0]              speed_reg;
    logic signed [17:0]       err_reg;

    logic [11:0] duty_out_reg;
    logic        top_out_reg;
    logic [15:0] speed_out_reg;

    ctrl_word_t             cw;
    logic                   s_accept, stall, adv, emit_fire, cfg_write;
    reg_idx_t               reg_idx;
    logic [15:0]            limit, tick_inc;
    logic                   window_end;
    logic [COUNT_WIDTH-1:0] mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_calc;
    logic [15:0]            speed_calc;
    logic signed [17:0]     err_calc;
    logic signed [18:0]     derr;
    logic signed [32:0]     esum_wide;
    logic signed [31:0]     esum_sat;
    logic signed [ACC_W-1:0] bias_term;
    logic [DUTY_Q_W-1:0]    duty_q, duty_clamp;
    logic [11:0]            duty_calc, tgt_masked;

    assign cw        = ucode(step_reg);
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign stall     = cw.emit && m_valid_reg && !m_tready;
    assign adv       = busy_reg && !stall;
    assign emit_fire = adv && cw.emit;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    assign limit      = (window_reg == 16'd0) ? 16'd1 : window_reg;
    assign tick_inc   = tick_reg + 16'd1;
    assign window_end = tick_inc >= limit;

    assign mag = pulse_reg[COUNT_WIDTH-1] ? (~pulse_reg + COUNT_WIDTH'(1)) : pulse_reg;
    assign derr = 19'(err_reg) - 19'(last_err_reg);

    always_comb begin
        case (cw.mul)
            MUL_MAG_SCALE: begin
                mul_a = MUL_A_W'(mag);
                mul_b = MUL_B_W'(scale_reg);
            end
            MUL_ERR_PROP: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(prop_reg);
            end
            MUL_SUM_INTEG: begin
                mul_a = MUL_A_W'(esum_reg);
                mul_b = MUL_B_W'(integ_reg);
            end
            MUL_DERR_DERIV: begin
                mul_a = MUL_A_W'(derr);
                mul_b = MUL_B_W'(deriv_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_calc  = mul_a * mul_b;
    assign speed_calc = (|prod_reg[PROD_W-1:24]) ? 16'hFFFF : prod_reg[23:8];
    assign err_calc   = $signed({6'd0, target_reg}) - $signed({2'd0, speed_reg});
    assign esum_wide  = 33'(esum_reg) + 33'(err_calc);
    assign esum_sat   = (esum_wide[32] != esum_wide[31]) ?
                        (esum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : esum_wide[31:0];
    assign bias_term  = $signed(ACC_W'({bias_reg, 10'd0}));
    assign duty_q     = acc_reg[ACC_W-1:10];
    assign duty_clamp = acc_reg[ACC_W-1] ? '0 : ((duty_q > PWM_MAX) ? PWM_MAX : duty_q);
    assign duty_calc  = (target_reg == 12'd0) ? 12'd0 : duty_clamp[11:0];
    assign tgt_masked = in_target_reg & TGT_MASK;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (s_accept) begin
            busy_next = 1'b1;
            step_next = entry_step(func_t'(s_tuser));
        end else if (adv) begin
            if (cw.done) begin
                busy_next = 1'b0;
            end else if (cw.jump == JMP_SHORT && !window_end) begin
                step_next = cw.jump_addr;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_comb begin
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= STEP_NOP;
            m_valid_reg  <= 1'b0;
            prop_reg     <= PROP_RST;
            integ_reg    <= INTEG_RST;
            deriv_reg    <= DERIV_RST;
            bias_reg     <= BIAS_RST;
            window_reg   <= WINDOW_RST;
            scale_reg    <= SCALE_RST;
            pulse_reg    <= '0;
            tick_reg     <= '0;
            esum_reg     <= '0;
            last_err_reg <= '0;
            target_reg   <= '0;
            dir_reg      <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write) begin
                case (reg_idx)
                    REG_PROP:   prop_reg   <= pwdata[15:0];
                    REG_INTEG:  integ_reg  <= pwdata[15:0];
                    REG_DERIV:  deriv_reg  <= pwdata[15:0];
                    REG_BIAS:   bias_reg   <= pwdata[11:0];
                    REG_WINDOW: window_reg <= pwdata[15:0];
                    REG_SCALE:  scale_reg  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (adv) begin
                case (cw.op)
                    OP_COUNT: begin
                        pulse_reg <= in_b_reg ? pulse_reg + COUNT_WIDTH'(1)
                                              : pulse_reg - COUNT_WIDTH'(1);
                    end
                    OP_TARGET: begin
                        target_reg   <= tgt_masked;
                        dir_reg      <= in_dir_reg;
                        esum_reg     <= '0;
                        last_err_reg <= '0;
                    end
                    OP_TICK: begin
                        tick_reg <= window_end ? 16'd0 : tick_inc;
                    end
                    OP_SPEED: begin
                        pulse_reg <= '0;
                    end
                    OP_ERR: begin
                        esum_reg <= esum_sat;
                    end
                    OP_LAST: begin
                        last_err_reg <= err_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_b_reg      <= s_tdata[0];
            in_target_reg <= s_tdata[12:1];
            in_dir_reg    <= s_tdata[13];
        end
        if (adv) begin
            if (cw.mul != MUL_NONE) begin
                prod_reg <= prod_calc;
            end
            case (cw.acc)
                ACC_BIAS: acc_reg <= bias_term;
                ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
                default: ;
            endcase
            case (cw.op)
                OP_SPEED: speed_reg <= speed_calc;
                OP_ERR:   err_reg   <= err_calc;
                default: ;
            endcase
        end
        if (emit_fire) begin
            if (cw.op == OP_TARGET) begin
                duty_out_reg  <= tgt_masked;
                top_out_reg   <= in_dir_reg;
                speed_out_reg <= 16'd0;
            end else begin
                duty_out_reg  <= duty_calc;
                top_out_reg   <= dir_reg;
                speed_out_reg <= speed_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, speed_out_reg, top_out_reg, duty_out_reg};

    always_comb begin
        case (reg_idx)
            REG_PROP:   prdata = {16'd0, prop_reg};
            REG_INTEG:  prdata = {16'd0, integ_reg};
            REG_DERIV:  prdata = {16'd0, deriv_reg};
            REG_BIAS:   prdata = {20'd0, bias_reg};
            REG_WINDOW: prdata = {16'd0, window_reg};
            REG_SCALE:  prdata = {16'd0, scale_reg};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/esp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module esp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [esp_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [esp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata
);
    import esp_pkg::*;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    // After reset the block is empty and ready for an item.
    `ESP_ASSERT_ALWAYS(a_reset_state, aclk, (!aresetn |=> (!m_tvalid && s_tready)), "reset state wrong")

    // An accepted item makes the sequencer busy, so the input is not ready in the cycle after the accept.
    `ESP_ASSERT(a_busy_after_accept, aclk, aresetn, ((s_tvalid && s_tready) |=> !s_tready), "ready after accept")

    // A stalled result item holds its payload.
    `ESP_ASSERT(a_out_hold, aclk, aresetn, ((m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))), "stalled item changed")

    // A written gain reads back in the following cycle.
    `ESP_ASSERT(a_prop_readback, aclk, aresetn, ((cfg_wr && paddr[ADDR_W-1:2] == REG_PROP) |=> (paddr[ADDR_W-1:2] != REG_PROP || prdata[15:0] == $past(pwdata[15:0]))), "gain readback wrong")

endmodule

bind encoder_speed_pid_pwm esp_checker u_esp_checker (.*);

`default_nettype wire

### bench/pid_duty_checker.sv
`timescale 1ns / 100ps

module pid_duty_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // s_tdata: enc_b [0], target_speed [12:1], direction [13], zero [15:14]
    input  logic [esp_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: func [1:0]
    input  logic [esp_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: pwm_duty [11:0], bridge_top [12], measured_speed [28:13], zero [31:29]
    input  logic [esp_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import esp_pkg::*;

    localparam longint DUTY_MAX = 4095;
    localparam longint SPEED_MAX = 65535;
    localparam longint ERR_HI = 131071;
    localparam longint ERR_LO = -131072;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;

    typedef struct packed {
        logic [11:0] duty;
        logic        bridge;
        logic [15:0] speed;
    } motor_out_t;

    motor_out_t expected_outputs[$];

    logic [15:0] kp, ki, kd, win_len, scale;
    logic [11:0] bias;
    logic [15:0] pulse_cnt, tick_cnt;
    longint      err_sum, prev_err;
    logic [11:0] target;
    logic        dir;

    function automatic logic [15:0] window_speed_of(logic [15:0] count, logic [15:0] q88);
        logic [16:0] mag;
        longint      prod;
        mag = count[15] ? 17'h10000 - {1'b0, count} : {1'b0, count};
        prod = (longint'(mag) * longint'(q88)) >>> 8;
        return (prod > SPEED_MAX) ? 16'hFFFF : prod[15:0];
    endfunction

    function automatic void note_mismatch(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endfunction

    task automatic close_window(output motor_out_t res);
        longint speed, err, acc, pid_sum, duty;
        speed = longint'(window_speed_of(pulse_cnt, scale));
        pulse_cnt = '0;
        err = longint'(target) - speed;
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;
        acc = err_sum + err;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        err_sum = acc;
        pid_sum = longint'(kp) * err + longint'(ki) * err_sum
                + longint'(kd) * (err - prev_err) + longint'(bias) * 1024;
        prev_err = err;
        if (pid_sum < 0 || target == 0) begin
            duty = 0;
        end else begin
            duty = pid_sum >>> 10;
            if (duty > DUTY_MAX) duty = DUTY_MAX;
        end
        res.duty = duty[11:0];
        res.bridge = dir;
        res.speed = speed[15:0];
    endtask

    task automatic apply_item(func_t f, logic [S_DATA_W-1:0] data);
        logic [15:0] limit;
        motor_out_t  res;
        case (f)
            FUNC_EDGE: begin
                pulse_cnt = data[0] ? pulse_cnt + 16'd1 : pulse_cnt - 16'd1;
            end
            FUNC_TICK: begin
                limit = (win_len == 16'd0) ? 16'd1 : win_len;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= limit) begin
                    tick_cnt = '0;
                    close_window(res);
                    expected_outputs.push_back(res);
                end
            end
            FUNC_TARGET: begin
                target = data[12:1];
                dir = data[13];
                err_sum = 0;
                prev_err = 0;
                res.duty = target;
                res.bridge = dir;
                res.speed = '0;
                expected_outputs.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        motor_out_t got, want;
        if (!aresetn) begin
            kp = PROP_RST;
            ki = INTEG_RST;
            kd = DERIV_RST;
            bias = BIAS_RST;
            win_len = WINDOW_RST;
            scale = SCALE_RST;
            pulse_cnt = '0;
            tick_cnt = '0;
            err_sum = 0;
            prev_err = 0;
            target = '0;
            dir = 1'b0;
            expected_outputs.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_PROP:   kp = pwdata[15:0];
                    REG_INTEG:  ki = pwdata[15:0];
                    REG_DERIV:  kd = pwdata[15:0];
                    REG_BIAS:   bias = pwdata[11:0];
                    REG_WINDOW: win_len = pwdata[15:0];
                    REG_SCALE:  scale = pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_item(func_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got.duty = m_tdata[11:0];
                got.bridge = m_tdata[12];
                got.speed = m_tdata[28:13];
                if (expected_outputs.size() == 0) begin
                    note_mismatch($sformatf("unexpected item duty %0d bridge %0d speed %0d",
                                            got.duty, got.bridge, got.speed));
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.duty != want.duty || got.bridge != want.bridge
                            || got.speed != want.speed) begin
                        note_mismatch($sformatf(
                            "duty %0d/%0d bridge %0d/%0d speed %0d/%0d (expected/actual)",
                            want.duty, got.duty, want.bridge, got.bridge,
                            want.speed, got.speed));
                    end
                end
            end
            pending <= expected_outputs.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import esp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SETTLE_CYCLES = 16;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int items_sent = 0;
    int idle_cycles = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int stall_left = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    encoder_speed_pid_pwm dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pid_duty_checker duty_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(50, 300);
        end
        ready_mode_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom);
            2: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 30);
                end
            end
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(func_t f, logic enc_b, logic [11:0] tgt, logic dirn);
        int gap;
        @(negedge aclk);
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {2'b00, dirn, tgt, enc_b};
        if (f != FUNC_NONE) items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {junk, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_controller(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                  logic [11:0] bias, logic [15:0] win, logic [15:0] scale);
        write_reg(REG_PROP, kp);
        write_reg(REG_INTEG, ki);
        write_reg(REG_DERIV, kd);
        write_reg(REG_BIAS, {4'($urandom), bias});
        write_reg(REG_WINDOW, win);
        write_reg(REG_SCALE, scale);
    endtask

    function automatic logic [11:0] pick_target();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic run_windows(int n_win, logic [15:0] win, int max_edges);
        int edges, ticks, up_pct, r;
        send_item(FUNC_TARGET, 1'($urandom), pick_target(), 1'($urandom));
        for (int w = 0; w < n_win; w++) begin
            edges = $urandom_range(0, max_edges);
            up_pct = $urandom_range(0, 100);
            ticks = (win == 16'd0) ? 1 : int'(win);
            while (edges > 0 || ticks > 0) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_item(FUNC_NONE, 1'($urandom), 12'($urandom), 1'($urandom));
                end else if (r < 6) begin
                    send_item(FUNC_TARGET, 1'($urandom), pick_target(), 1'($urandom));
                end else if (edges > 0 && (ticks <= 1 || $urandom_range(0, 1) == 1)) begin
                    send_item(FUNC_EDGE, $urandom_range(0, 99) < up_pct,
                              12'($urandom), 1'($urandom));
                    edges--;
                end else begin
                    send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 1'($urandom));
                    ticks--;
                end
            end
        end
    endtask

    initial begin
        int          phase;
        int          n_win, max_e;
        logic [15:0] c_kp, c_ki, c_kd, c_win, c_scale;
        logic [11:0] c_bias;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_NONE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A window length of zero closes a window on every tick.
        write_reg(REG_WINDOW, 16'd0);
        send_item(FUNC_TICK, 1'b0, 12'd0, 1'b0);
        send_item(FUNC_TARGET, 1'b0, 12'hFFF, 1'b1);
        repeat (3) send_item(FUNC_EDGE, 1'b1, 12'hFFF, 1'b1);
        send_item(FUNC_EDGE, 1'b0, 12'd0, 1'b0);
        send_item(FUNC_TICK, 1'b1, 12'hFFF, 1'b1);
        send_item(FUNC_NONE, 1'b1, 12'hFFF, 1'b1);
        repeat (5) send_item(FUNC_EDGE, 1'b0, 12'hFFF, 1'b1);
        send_item(FUNC_TICK, 1'b0, 12'd0, 1'b0);
        send_item(FUNC_TARGET, 1'b1, 12'd0, 1'b0);
        send_item(FUNC_EDGE, 1'b1, 12'd0, 1'b0);
        send_item(FUNC_TICK, 1'b1, 12'd0, 1'b1);
        send_item(FUNC_TARGET, 1'b0, 12'd1, 1'b1);
        send_item(FUNC_TICK, 1'b0, 12'd0, 1'b0);
        settle();

        // Shortening the window below the ticks already counted ends it on the next tick.
        write_reg(REG_WINDOW, 16'hFFFF);
        repeat (3) send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 1'($urandom));
        settle();
        write_reg(REG_WINDOW, 16'd2);
        send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 1'($urandom));
        settle();

        // Counting down from zero wraps the pulse counter to its top values.
        write_reg(REG_WINDOW, 16'd1);
        gaps_on = 1'b0;
        repeat (3) send_item(FUNC_EDGE, 1'b0, 12'($urandom), 1'($urandom));
        send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 1'($urandom));
        send_item(FUNC_EDGE, 1'b0, 12'($urandom), 1'($urandom));
        send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 1'($urandom));
        settle();

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            n_win = $urandom_range(5, 20);
            max_e = $urandom_range(0, 40);
            c_kp = 16'($urandom_range(0, 8191));
            c_ki = 16'($urandom_range(0, 255));
            c_kd = 16'($urandom_range(0, 4095));
            c_bias = 12'($urandom);
            c_win = 16'($urandom_range(0, 6));
            c_scale = 16'($urandom_range(0, 16383));
            case (phase)
                0: begin
                    {c_kp, c_ki, c_kd} = {PROP_RST, INTEG_RST, DERIV_RST};
                    {c_bias, c_win, c_scale} = {BIAS_RST, WINDOW_RST, SCALE_RST};
                    n_win = 2;
                end
                1: begin
                    {c_kp, c_ki, c_kd, c_bias, c_win, c_scale} = '0;
                    c_win = 16'd1;
                end
                2: begin
                    {c_kp, c_ki, c_kd, c_bias, c_scale} = '1;
                    c_win = 16'd2;
                end
                3: begin
                    {c_kp, c_ki, c_kd, c_bias, c_win, c_scale} =
                        {16'hFFFF, 16'd0, 16'd0, 12'd0, 16'd1, 16'hFFFF};
                end
                4: begin
                    {c_kp, c_ki, c_kd, c_bias, c_win, c_scale} =
                        {16'd0, 16'hFFFF, 16'd0, 12'hFFF, 16'd1, 16'd256};
                end
                5: begin
                    {c_kp, c_ki, c_kd, c_bias, c_win, c_scale} =
                        {16'd0, 16'd0, 16'hFFFF, 12'd0, 16'd1, 16'd512};
                end
                default: begin
                end
            endcase
            set_controller(c_kp, c_ki, c_kd, c_bias, c_win, c_scale);
            gaps_on = ($urandom_range(0, 3) != 0);
            run_windows(n_win, c_win, max_e);
            settle();
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
